[rtl/core/cci_pkg.sv]
// Package for the circle collision impulse resolver: request and result
// structs, status codes, sequencer enums and the saturation helper.
// No dependencies.
package cci_pkg;

	// Default fraction bits of the fixed-point positions and velocities
	localparam int FRAC_BITS_DEF = 16;
	// Restitution is always unsigned Q1.16 (17 bits)
	localparam int E_BITS = 16;
	localparam int ONE_E = 65536;
	// Shared multiplier: MW-bit operand, second operand taken in two halves
	localparam int MW = 40;
	localparam int HB = MW / 2;
	localparam int PW = 80;
	localparam int SQ_STEPS = 32;

	typedef struct packed {
		logic              is_second;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic [30:0]       radius;
		logic [30:0]       mass;
		logic [16:0]       restitution;
	} ball_t;

	typedef enum logic [1:0] {
		STAT_RESOLVED   = 2'd0,
		STAT_SEPARATING = 2'd1,
		STAT_COINCIDENT = 2'd2,
		STAT_NO_A       = 2'd3
	} status_t;

	typedef struct packed {
		logic              ball_index;
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_vel_x;
		logic signed [31:0] new_vel_y;
		logic [1:0]        status;
		logic              touching;
		logic              last;
	} result_t;

	typedef enum logic [3:0] {
		S_IDLE, S_PREP, S_MUL0, S_MUL1, S_DIVLD, S_DIV, S_SQRT, S_WB, S_EMA, S_EMB
	} fsm_t;

	// Steps of the resolve program, run in this order
	typedef enum logic [4:0] {
		SP_UX2, SP_UY2, SP_RS2, SP_DX2, SP_DY2, SP_SQRT, SP_NX, SP_NY,
		SP_VNX, SP_VNY, SP_K, SP_SHA, SP_SHB, SP_FA, SP_FB,
		SP_AVX, SP_AVY, SP_BVX, SP_BVY, SP_OX, SP_OY
	} step_t;

	// Clamp a wide signed value to 32-bit signed
	function automatic logic signed [31:0] sat32(input logic signed [PW-1:0] v);
		logic signed [PW-1:0] hi;
		logic signed [PW-1:0] lo;
		hi = PW'(64'sh7FFF_FFFF);
		lo = -PW'(64'sh8000_0000);
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end else begin
			return v[31:0];
		end
	endfunction

endpackage

[rtl/core/circle_collision_impulse_resolver.sv]
// Circle collision impulse resolver, top level.
// Uses cci_pkg for types, constants and sat32.
//
// Usage: send two requests on the ball channel (ball_valid/ball_stall/ball).
// A request with is_second = 0 stores ball A and gives no result. A request
// with is_second = 1 resolves ball B against stored ball A and yields two
// results on the result channel (result_valid/result_stall/result): ball A
// then ball B (last = 1). A second ball with no ball A stored yields one
// result, ball B unchanged, status no-A.
// Sequencing: ball A is taken while idle and starts no work. For a resolved
// pair, between ball B and the first result the sequencer runs sixteen
// products on one shared multiplier, each through the MUL0, MUL1 and WB
// states, one 32-step square root and four FRAC_BITS+2 step divisions.
// ball_stall is high while the sequencer is not idle (a pair or a no-A result).
// A result waits in the output register while result_stall is high; the
// sequencer holds before loading the next one and the next request is taken
// once both results are loaded. Reset clears the sequencer, the output valid
// and the stored-ball flag; no result is pending after reset.
module circle_collision_impulse_resolver #(
	parameter int FRAC_BITS = cci_pkg::FRAC_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             ball_valid,
	output logic             ball_stall,
	input  cci_pkg::ball_t   ball,
	output logic             result_valid,
	input  logic             result_stall,
	output cci_pkg::result_t result
);

	localparam int QB = FRAC_BITS + 2;
	localparam int CW = 6;
	localparam int MW = cci_pkg::MW;
	localparam int HB = cci_pkg::HB;
	localparam int PW = cci_pkg::PW;

	cci_pkg::fsm_t  state_q, state_d;
	cci_pkg::step_t step_q, step_d;

	cci_pkg::ball_t a_q, b_q;
	logic loaded_q;

	logic signed [32:0] rvx_q, rvy_q;
	logic [32:0] ux_q, uy_q, rsum_q;
	logic signed [31:0] dx_q, dy_q;
	logic [31:0] msum_q;
	logic [30:0] am_q, bm_q;
	logic [17:0] onee_q;

	logic [65:0] t_q;
	logic touch_q;
	logic [31:0] dist_q;
	logic [63:0] sqv_q;
	logic [33:0] sqr_q;
	logic [31:0] dvr_q;
	logic [QB-1:0] dvq_q;
	logic dvn_q;
	logic [CW-1:0] cnt_q;

	logic signed [MW-1:0] nx_q, ny_q, nvan_q, k_q, fa_q, fb_q, ov_q;
	logic [QB-1:0] sha_q, shb_q;
	logic signed [PW-1:0] acc_q;

	logic signed [31:0] rpax_q, rpay_q, rvax_q, rvay_q;
	logic signed [31:0] rpbx_q, rpby_q, rvbx_q, rvby_q;
	logic [1:0] status_q;

	cci_pkg::result_t res_q;
	logic res_valid_q;

	logic out_load, out_b, wb_exit, accept;

	// Request side
	assign ball_stall = (state_q != cci_pkg::S_IDLE);
	assign accept = ball_valid && (state_q == cci_pkg::S_IDLE);
	assign result_valid = res_valid_q;
	assign result = res_q;

	// Preparation values from the two balls
	logic signed [32:0] dxf_w, dyf_w;
	logic [30:0] am_w, bm_w;
	logic [16:0] emin_w;
	always_comb begin
		dxf_w = 33'(b_q.pos_x) - 33'(a_q.pos_x);
		dyf_w = 33'(b_q.pos_y) - 33'(a_q.pos_y);
		am_w = (a_q.mass == '0) ? 31'd1 : a_q.mass;
		bm_w = (b_q.mass == '0) ? 31'd1 : b_q.mass;
		emin_w = (a_q.restitution < b_q.restitution) ? a_q.restitution : b_q.restitution;
		if (emin_w > 17'(cci_pkg::ONE_E)) begin
			emin_w = 17'(cci_pkg::ONE_E);
		end
	end

	// Select multiplier operands for the current step
	logic signed [MW-1:0] ma, mb;
	logic madd;
	always_comb begin
		ma = '0;
		mb = '0;
		madd = 1'b0;
		case (step_q)
			cci_pkg::SP_UX2: begin
				ma = $signed({{(MW-33){1'b0}}, ux_q});
				mb = ma;
			end
			cci_pkg::SP_UY2: begin
				ma = $signed({{(MW-33){1'b0}}, uy_q});
				mb = ma;
				madd = 1'b1;
			end
			cci_pkg::SP_RS2: begin
				ma = $signed({{(MW-33){1'b0}}, rsum_q});
				mb = ma;
			end
			cci_pkg::SP_DX2: begin
				ma = MW'(dx_q);
				mb = MW'(dx_q);
			end
			cci_pkg::SP_DY2: begin
				ma = MW'(dy_q);
				mb = MW'(dy_q);
				madd = 1'b1;
			end
			cci_pkg::SP_VNX: begin
				ma = nx_q;
				mb = MW'(rvx_q);
			end
			cci_pkg::SP_VNY: begin
				ma = ny_q;
				mb = MW'(rvy_q);
				madd = 1'b1;
			end
			cci_pkg::SP_K: begin
				ma = $signed({{(MW-18){1'b0}}, onee_q});
				mb = nvan_q;
			end
			cci_pkg::SP_FA: begin
				ma = k_q;
				mb = $signed({{(MW-QB){1'b0}}, sha_q});
			end
			cci_pkg::SP_FB: begin
				ma = k_q;
				mb = $signed({{(MW-QB){1'b0}}, shb_q});
			end
			cci_pkg::SP_AVX: begin
				ma = nx_q;
				mb = fa_q;
			end
			cci_pkg::SP_AVY: begin
				ma = ny_q;
				mb = fa_q;
			end
			cci_pkg::SP_BVX: begin
				ma = nx_q;
				mb = fb_q;
			end
			cci_pkg::SP_BVY: begin
				ma = ny_q;
				mb = fb_q;
			end
			cci_pkg::SP_OX: begin
				ma = nx_q;
				mb = ov_q;
			end
			cci_pkg::SP_OY: begin
				ma = ny_q;
				mb = ov_q;
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	// Shared multiplier: low half of mb (unsigned), then high half (signed)
	logic signed [HB:0] mbp;
	logic signed [MW+HB:0] prod;
	always_comb begin
		if (state_q == cci_pkg::S_MUL1) begin
			mbp = $signed({mb[MW-1], mb[MW-1:HB]});
		end else begin
			mbp = $signed({1'b0, mb[HB-1:0]});
		end
		prod = ma * mbp;
	end

	// Square root step: two radicand bits per cycle
	logic [35:0] sq_rn;
	logic [35:0] sq_tr;
	logic sq_ge;
	always_comb begin
		sq_rn = {sqr_q, sqv_q[63:62]};
		sq_tr = {2'b00, dist_q, 2'b01};
		sq_ge = (sq_rn >= sq_tr);
	end

	// Division step: one quotient bit per cycle
	logic [31:0] den;
	logic [32:0] dv_r2;
	logic dv_ge;
	logic [31:0] dv_mag;
	logic dv_neg;
	logic signed [MW-1:0] dv_val;
	always_comb begin
		den = (step_q == cci_pkg::SP_NX || step_q == cci_pkg::SP_NY) ? dist_q : msum_q;
		dv_r2 = {dvr_q, dvq_q[QB-1]};
		dv_ge = (dv_r2 >= {1'b0, den});
		case (step_q)
			cci_pkg::SP_NX: begin
				dv_mag = dx_q[31] ? 32'(-dx_q) : 32'(dx_q);
				dv_neg = dx_q[31];
			end
			cci_pkg::SP_NY: begin
				dv_mag = dy_q[31] ? 32'(-dy_q) : 32'(dy_q);
				dv_neg = dy_q[31];
			end
			cci_pkg::SP_SHA: begin
				dv_mag = {1'b0, bm_q};
				dv_neg = 1'b0;
			end
			default: begin
				dv_mag = {1'b0, am_q};
				dv_neg = 1'b0;
			end
		endcase
		dv_val = dvn_q ? -$signed({{(MW-QB){1'b0}}, dvq_q}) : $signed({{(MW-QB){1'b0}}, dvq_q});
	end

	// Write-back helpers
	logic signed [PW-1:0] acc_f;
	logic signed [34:0] ov_w;
	assign acc_f = acc_q >>> FRAC_BITS;
	assign ov_w = $signed({2'b00, rsum_q}) - $signed({3'b000, dist_q});

	always_comb begin
		case (step_q)
			cci_pkg::SP_DY2: wb_exit = (acc_q[63:0] == '0);
			cci_pkg::SP_VNY: wb_exit = (acc_q > 0);
			cci_pkg::SP_OY:  wb_exit = 1'b1;
			default:         wb_exit = 1'b0;
		endcase
	end

	// Sequencer: next state, next step and output loads
	always_comb begin
		state_d = state_q;
		step_d = step_q;
		out_load = 1'b0;
		out_b = 1'b0;
		case (state_q)
			cci_pkg::S_IDLE: begin
				if (ball_valid && ball.is_second) begin
					state_d = loaded_q ? cci_pkg::S_PREP : cci_pkg::S_EMB;
				end
			end
			cci_pkg::S_PREP: begin
				step_d = cci_pkg::SP_UX2;
				state_d = cci_pkg::S_MUL0;
			end
			cci_pkg::S_MUL0: state_d = cci_pkg::S_MUL1;
			cci_pkg::S_MUL1: state_d = cci_pkg::S_WB;
			cci_pkg::S_DIVLD: state_d = cci_pkg::S_DIV;
			cci_pkg::S_DIV, cci_pkg::S_SQRT: begin
				if (cnt_q == '0) begin
					state_d = cci_pkg::S_WB;
				end
			end
			cci_pkg::S_WB: begin
				if (wb_exit) begin
					state_d = cci_pkg::S_EMA;
				end else begin
					step_d = cci_pkg::step_t'(step_q + 5'd1);
					if (step_d == cci_pkg::SP_SQRT) begin
						state_d = cci_pkg::S_SQRT;
					end else if (step_d inside {cci_pkg::SP_NX, cci_pkg::SP_NY,
							cci_pkg::SP_SHA, cci_pkg::SP_SHB}) begin
						state_d = cci_pkg::S_DIVLD;
					end else begin
						state_d = cci_pkg::S_MUL0;
					end
				end
			end
			cci_pkg::S_EMA: begin
				if (!res_valid_q || !result_stall) begin
					out_load = 1'b1;
					state_d = cci_pkg::S_EMB;
				end
			end
			cci_pkg::S_EMB: begin
				if (!res_valid_q || !result_stall) begin
					out_load = 1'b1;
					out_b = 1'b1;
					state_d = cci_pkg::S_IDLE;
				end
			end
			default: state_d = cci_pkg::S_IDLE;
		endcase
	end

	// Hold control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cci_pkg::S_IDLE;
			step_q <= cci_pkg::SP_UX2;
			loaded_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q <= step_d;
			if (accept) begin
				loaded_q <= !ball.is_second;
			end
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		// Capture requests
		if (accept) begin
			if (!ball.is_second) begin
				a_q <= ball;
			end else begin
				b_q <= ball;
				if (!loaded_q) begin
					status_q <= cci_pkg::STAT_NO_A;
					touch_q <= 1'b0;
				end
			end
		end

		// Form differences, sums and clamps
		if (state_q == cci_pkg::S_PREP) begin
			ux_q <= dxf_w[32] ? 33'(-dxf_w) : 33'(dxf_w);
			uy_q <= dyf_w[32] ? 33'(-dyf_w) : 33'(dyf_w);
			dx_q <= (dxf_w[32] != dxf_w[31]) ?
				(dxf_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dxf_w[31:0];
			dy_q <= (dyf_w[32] != dyf_w[31]) ?
				(dyf_w[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : dyf_w[31:0];
			rsum_q <= 33'(a_q.radius) + 33'(b_q.radius);
			rvx_q <= 33'(b_q.vel_x) - 33'(a_q.vel_x);
			rvy_q <= 33'(b_q.vel_y) - 33'(a_q.vel_y);
			am_q <= am_w;
			bm_q <= bm_w;
			msum_q <= 32'(am_w) + 32'(bm_w);
			onee_q <= 18'(cci_pkg::ONE_E) + 18'(emin_w);
		end

		// Multiply and accumulate
		if (state_q == cci_pkg::S_MUL0) begin
			acc_q <= (madd ? acc_q : PW'(0)) + PW'(prod);
		end else if (state_q == cci_pkg::S_MUL1) begin
			acc_q <= acc_q + (PW'(prod) <<< HB);
		end

		// Advance the square root
		if (state_q == cci_pkg::S_SQRT) begin
			sqr_q <= sq_ge ? 34'(sq_rn - sq_tr) : sq_rn[33:0];
			dist_q <= {dist_q[30:0], sq_ge};
			sqv_q <= sqv_q << 2;
			cnt_q <= cnt_q - 1'b1;
		end

		// Load and advance the divider
		if (state_q == cci_pkg::S_DIVLD) begin
			dvr_q <= dv_mag >> 2;
			dvq_q <= {dv_mag[1:0], {FRAC_BITS{1'b0}}};
			dvn_q <= dv_neg;
			cnt_q <= CW'(QB - 1);
			if (step_q == cci_pkg::SP_NX) begin
				ov_q <= MW'(ov_w >>> 1);
			end
		end else if (state_q == cci_pkg::S_DIV) begin
			dvr_q <= dv_ge ? 32'(dv_r2 - {1'b0, den}) : dv_r2[31:0];
			dvq_q <= {dvq_q[QB-2:0], dv_ge};
			cnt_q <= cnt_q - 1'b1;
		end

		// Write back the finished step
		if (state_q == cci_pkg::S_WB) begin
			case (step_q)
				cci_pkg::SP_UY2: t_q <= acc_q[65:0];
				cci_pkg::SP_RS2: touch_q <= (t_q <= acc_q[65:0]);
				cci_pkg::SP_DY2: begin
					if (acc_q[63:0] == '0) begin
						status_q <= cci_pkg::STAT_COINCIDENT;
					end else begin
						sqv_q <= acc_q[63:0];
						sqr_q <= '0;
						dist_q <= '0;
						cnt_q <= CW'(cci_pkg::SQ_STEPS - 1);
					end
				end
				cci_pkg::SP_NX: nx_q <= dv_val;
				cci_pkg::SP_NY: ny_q <= dv_val;
				cci_pkg::SP_VNY: begin
					if (acc_q > 0) begin
						status_q <= cci_pkg::STAT_SEPARATING;
					end else begin
						nvan_q <= MW'(-acc_f);
					end
				end
				cci_pkg::SP_K: k_q <= MW'(acc_q >>> cci_pkg::E_BITS);
				cci_pkg::SP_SHA: sha_q <= dvq_q;
				cci_pkg::SP_SHB: shb_q <= dvq_q;
				cci_pkg::SP_FA: fa_q <= MW'(acc_f);
				cci_pkg::SP_FB: fb_q <= MW'(acc_f);
				cci_pkg::SP_AVX: rvax_q <= cci_pkg::sat32(PW'(a_q.vel_x) - acc_f);
				cci_pkg::SP_AVY: rvay_q <= cci_pkg::sat32(PW'(a_q.vel_y) - acc_f);
				cci_pkg::SP_BVX: rvbx_q <= cci_pkg::sat32(PW'(b_q.vel_x) + acc_f);
				cci_pkg::SP_BVY: rvby_q <= cci_pkg::sat32(PW'(b_q.vel_y) + acc_f);
				cci_pkg::SP_OX: begin
					rpax_q <= cci_pkg::sat32(PW'(a_q.pos_x) - acc_f);
					rpbx_q <= cci_pkg::sat32(PW'(b_q.pos_x) + acc_f);
				end
				cci_pkg::SP_OY: begin
					rpay_q <= cci_pkg::sat32(PW'(a_q.pos_y) - acc_f);
					rpby_q <= cci_pkg::sat32(PW'(b_q.pos_y) + acc_f);
					status_q <= cci_pkg::STAT_RESOLVED;
				end
				default: ;
			endcase
		end

		// Load the output register: computed values when resolved, else unchanged
		if (out_load) begin
			res_q.status <= status_q;
			res_q.touching <= touch_q;
			res_q.ball_index <= out_b;
			res_q.last <= out_b;
			if (out_b) begin
				res_q.new_pos_x <= (status_q == cci_pkg::STAT_RESOLVED) ? rpbx_q : b_q.pos_x;
				res_q.new_pos_y <= (status_q == cci_pkg::STAT_RESOLVED) ? rpby_q : b_q.pos_y;
				res_q.new_vel_x <= (status_q == cci_pkg::STAT_RESOLVED) ? rvbx_q : b_q.vel_x;
				res_q.new_vel_y <= (status_q == cci_pkg::STAT_RESOLVED) ? rvby_q : b_q.vel_y;
			end else begin
				res_q.new_pos_x <= (status_q == cci_pkg::STAT_RESOLVED) ? rpax_q : a_q.pos_x;
				res_q.new_pos_y <= (status_q == cci_pkg::STAT_RESOLVED) ? rpay_q : a_q.pos_y;
				res_q.new_vel_x <= (status_q == cci_pkg::STAT_RESOLVED) ? rvax_q : a_q.vel_x;
				res_q.new_vel_y <= (status_q == cci_pkg::STAT_RESOLVED) ? rvay_q : a_q.vel_y;
			end
		end
	end

endmodule

[rtl/core/cci_checker.sv]
// Port-level checks for the circle collision impulse resolver.
// Uses cci_pkg; bound to circle_collision_impulse_resolver below.
module cci_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             ball_valid,
	input logic             ball_stall,
	input cci_pkg::ball_t   ball,
	input logic             result_valid,
	input logic             result_stall,
	input cci_pkg::result_t result
);

	// Hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("stalled result dropped or changed");

	// Flag the end of a pair on ball B only
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> result.last == result.ball_index)
		else $error("last does not match ball_index");

	// Report a missing ball A on ball B, not touching
	a_no_a: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == cci_pkg::STAT_NO_A |->
		result.ball_index && !result.touching)
		else $error("bad no-A result");

	// Coincident centres always touch
	a_coinc: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.status == cci_pkg::STAT_COINCIDENT |-> result.touching)
		else $error("coincident result not touching");

endmodule

bind circle_collision_impulse_resolver cci_checker u_cci_checker (.*);

[tb/sv/circle_collision_impulse_resolver_test.sv]
// Testbench for the circle collision impulse resolver: directed table of
// ball pairs, then random pairs, each checked against a local predictor.
// Depends on cci_pkg and circle_collision_impulse_resolver.
`timescale 1ns / 100ps

module circle_collision_impulse_resolver_test;

	localparam int FB = 16;
	localparam int N_RANDOM = 700;
	localparam int N_DIRECTED = 22;

	logic clk;
	logic arst_n;
	logic ball_valid;
	logic ball_stall;
	cci_pkg::ball_t ball;
	logic result_valid;
	logic result_stall;
	cci_pkg::result_t result;

	circle_collision_impulse_resolver #(.FRAC_BITS(FB)) dut (
		.clk(clk), .arst_n(arst_n),
		.ball_valid(ball_valid), .ball_stall(ball_stall), .ball(ball),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	// Predictor state: the stored first ball
	cci_pkg::ball_t held_a;
	bit a_loaded;
	cci_pkg::result_t pending_q[$];
	int n_errors;
	int n_results;
	bit quiet_sink;

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return longint'(r);
	endfunction

	function automatic longint quot_trunc(input longint num, input longint den);
		longint unsigned m;
		m = longint'(num < 0 ? -num : num) / den;
		return num < 0 ? -longint'(m) : longint'(m);
	endfunction

	function automatic cci_pkg::result_t make_result(input bit idx, input longint px,
			input longint py, input longint vx, input longint vy,
			input cci_pkg::status_t st, input bit t);
		cci_pkg::result_t r;
		r.ball_index = idx;
		r.new_pos_x = 32'(clamp32(px));
		r.new_pos_y = 32'(clamp32(py));
		r.new_vel_x = 32'(clamp32(vx));
		r.new_vel_y = 32'(clamp32(vy));
		r.status = st;
		r.touching = t;
		r.last = idx;
		return r;
	endfunction

	// Work out the results of one accepted ball and queue them
	task automatic predict_collision(input cci_pkg::ball_t b);
		longint apx, apy, avx, avy, bpx, bpy, bvx, bvy;
		longint dxf, dyf, dx, dy, dist_v, nx, ny, vn, van, k, msum;
		longint sha, shb, fa, fb, ov, ox, oy, rsum_s;
		longint unsigned ux, uy, rsum, rs2, dx2, dy2, dsq, am, bm, e;
		bit t;
		if (!b.is_second) begin
			held_a = b;
			a_loaded = 1;
			return;
		end
		bpx = b.pos_x; bpy = b.pos_y; bvx = b.vel_x; bvy = b.vel_y;
		if (!a_loaded) begin
			pending_q.push_back(make_result(1, bpx, bpy, bvx, bvy, cci_pkg::STAT_NO_A, 0));
			return;
		end
		a_loaded = 0;
		apx = held_a.pos_x; apy = held_a.pos_y;
		avx = held_a.vel_x; avy = held_a.vel_y;
		dxf = bpx - apx;
		dyf = bpy - apy;
		ux = dxf < 0 ? -dxf : dxf;
		uy = dyf < 0 ? -dyf : dyf;
		rsum = longint'(held_a.radius) + longint'(b.radius);
		rs2 = rsum * rsum;
		dx2 = ux * ux;
		dy2 = uy * uy;
		t = (dx2 <= rs2 && dy2 <= rs2 - dx2);
		dx = clamp32(dxf);
		dy = clamp32(dyf);
		dsq = longint'(dx * dx) + longint'(dy * dy);
		if (dsq == 0) begin
			pending_q.push_back(make_result(0, apx, apy, avx, avy,
				cci_pkg::STAT_COINCIDENT, t));
			pending_q.push_back(make_result(1, bpx, bpy, bvx, bvy,
				cci_pkg::STAT_COINCIDENT, t));
			return;
		end
		dist_v = root_floor(dsq);
		nx = quot_trunc(dx <<< FB, dist_v);
		ny = quot_trunc(dy <<< FB, dist_v);
		vn = nx * (bvx - avx) + ny * (bvy - avy);
		if (vn > 0) begin
			pending_q.push_back(make_result(0, apx, apy, avx, avy,
				cci_pkg::STAT_SEPARATING, t));
			pending_q.push_back(make_result(1, bpx, bpy, bvx, bvy,
				cci_pkg::STAT_SEPARATING, t));
			return;
		end
		van = floor_shift(vn, FB);
		e = held_a.restitution < b.restitution ? held_a.restitution : b.restitution;
		if (e > cci_pkg::ONE_E) e = cci_pkg::ONE_E;
		k = floor_shift((cci_pkg::ONE_E + longint'(e)) * (-van), cci_pkg::E_BITS);
		am = held_a.mass == 0 ? 1 : held_a.mass;
		bm = b.mass == 0 ? 1 : b.mass;
		msum = am + bm;
		sha = (bm << FB) / msum;
		shb = (am << FB) / msum;
		fa = floor_shift(k * sha, FB);
		fb = floor_shift(k * shb, FB);
		rsum_s = rsum;
		ov = floor_shift(rsum_s - dist_v, 1);
		ox = floor_shift(nx * ov, FB);
		oy = floor_shift(ny * ov, FB);
		pending_q.push_back(make_result(0, apx - ox, apy - oy,
			avx - floor_shift(nx * fa, FB), avy - floor_shift(ny * fa, FB),
			cci_pkg::STAT_RESOLVED, t));
		pending_q.push_back(make_result(1, bpx + ox, bpy + oy,
			bvx + floor_shift(nx * fb, FB), bvy + floor_shift(ny * fb, FB),
			cci_pkg::STAT_RESOLVED, t));
	endtask

	function automatic cci_pkg::ball_t make_ball(input bit second, input int px,
			input int py, input int vx, input int vy, input int rad, input int m,
			input int rest);
		cci_pkg::ball_t b;
		b.is_second = second;
		b.pos_x = px; b.pos_y = py; b.vel_x = vx; b.vel_y = vy;
		b.radius = 31'(rad); b.mass = 31'(m); b.restitution = 17'(rest);
		return b;
	endfunction

	// Random ball: mostly near-range values so pairs collide, some extremes
	function automatic cci_pkg::ball_t random_ball(input bit second);
		cci_pkg::ball_t b;
		int sel;
		sel = $urandom_range(0, 9);
		b = make_ball(second, 0, 0, 0, 0, 0, 0, 0);
		if (sel < 7) begin
			b.pos_x = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			b.pos_y = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
			b.vel_x = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			b.vel_y = $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
			b.radius = 31'($urandom_range(0, 32'h0004_0000));
			b.mass = 31'($urandom_range(1, 32'h0010_0000));
		end else begin
			b.pos_x = $urandom; b.pos_y = $urandom;
			b.vel_x = $urandom; b.vel_y = $urandom;
			b.radius = 31'($urandom); b.mass = 31'($urandom);
		end
		b.restitution = 17'($urandom_range(0, 131071));
		if (sel == 9) b.restitution = 17'($urandom_range(0, 65536));
		return b;
	endfunction

	// Directed table and pre-typed results (status checked where marked)
	cci_pkg::ball_t dir_ball[N_DIRECTED];
	int dir_status[N_DIRECTED];

	initial begin
		// Ball B with nothing stored
		dir_ball[0] = make_ball(1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 131071);
		dir_status[0] = cci_pkg::STAT_NO_A;
		// Coincident centres
		dir_ball[1] = make_ball(0, 32'h0001_0000, 32'h0001_0000, 0, 0, 65536, 65536, 65536);
		dir_status[1] = -1;
		dir_ball[2] = make_ball(1, 32'h0001_0000, 32'h0001_0000, 5, 5, 65536, 65536, 65536);
		dir_status[2] = cci_pkg::STAT_COINCIDENT;
		// Head-on approach, equal masses
		dir_ball[3] = make_ball(0, 0, 0, 32'h0001_0000, 0, 65536, 65536, 65536);
		dir_status[3] = -1;
		dir_ball[4] = make_ball(1, 32'h0001_8000, 0, -32'sh0001_0000, 0, 65536,
			65536, 65536);
		dir_status[4] = cci_pkg::STAT_RESOLVED;
		// Separating
		dir_ball[5] = make_ball(0, 0, 0, -32'sh0001_0000, 0, 65536, 65536, 0);
		dir_status[5] = -1;
		dir_ball[6] = make_ball(1, 32'h0001_0000, 0, 32'h0001_0000, 0, 65536, 65536, 0);
		dir_status[6] = cci_pkg::STAT_SEPARATING;
		// Zero masses, restitution above one
		dir_ball[7] = make_ball(0, 0, 0, 32'h0002_0000, 32'h0001_0000, 0, 0, 131071);
		dir_status[7] = -1;
		dir_ball[8] = make_ball(1, 32'h0000_8000, 32'h0000_8000, 0, 0, 0, 0, 100000);
		dir_status[8] = -1;
		// Huge centre offset, max radii
		dir_ball[9] = make_ball(0, 32'sh8000_0000, 32'sh8000_0000, 32'sh7FFF_FFFF,
			32'sh7FFF_FFFF, 32'h7FFF_FFFF, 1, 0);
		dir_status[9] = -1;
		dir_ball[10] = make_ball(1, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000,
			32'sh8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 65536);
		dir_status[10] = cci_pkg::STAT_RESOLVED;
		// Non-touching approach draws the balls together
		dir_ball[11] = make_ball(0, 0, 0, 32'h0001_0000, 0, 1, 65536, 32768);
		dir_status[11] = -1;
		dir_ball[12] = make_ball(1, 32'h0010_0000, 32'h0003_0000, 0, 0, 1, 3, 65536);
		dir_status[12] = cci_pkg::STAT_RESOLVED;
		// Ball A replaced before the pair completes
		dir_ball[13] = make_ball(0, 32'h0100_0000, 0, 0, 0, 100, 100, 100);
		dir_status[13] = -1;
		dir_ball[14] = make_ball(0, 0, 32'h0000_4000, 0, -32'sh0000_1000, 32'h0000_8000,
			32'h0002_0000, 40000);
		dir_status[14] = -1;
		dir_ball[15] = make_ball(1, 0, 0, 0, 32'h0000_1000, 32'h0000_8000, 32'h0000_0100,
			50000);
		dir_status[15] = cci_pkg::STAT_RESOLVED;
		// Pair consumed: next B has no A
		dir_ball[16] = make_ball(1, -1, -1, -1, -1, 0, 1, 0);
		dir_status[16] = cci_pkg::STAT_NO_A;
		// Exactly touching diagonal, extreme negative values
		dir_ball[17] = make_ball(0, 0, 0, 0, 0, 32'h0001_0000, 32'h7FFF_FFFF, 65536);
		dir_status[17] = -1;
		dir_ball[18] = make_ball(1, 32'h0003_0000, 32'h0004_0000, -32'sh0000_0001, 0,
			32'h0004_0000, 1, 65536);
		dir_status[18] = -1;
		dir_ball[19] = make_ball(0, 32'sh8000_0000, 0, 32'sh8000_0000, 0, 0, 1, 0);
		dir_status[19] = -1;
		dir_ball[20] = make_ball(1, 32'sh8000_0000, 1, 32'sh7FFF_FFFF, 0, 0, 1, 0);
		dir_status[20] = -1;
		dir_ball[21] = make_ball(1, 0, 0, 0, 0, 0, 1, 0);
		dir_status[21] = cci_pkg::STAT_NO_A;
	end

	// Clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Safety limit: end the test with a mismatch message if it hangs
	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	// Result sink: random stall bursts, compare each accepted result
	initial begin
		int burst;
		cci_pkg::result_t want;
		result_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (result_valid && !result_stall && arst_n) begin
				n_results++;
				if (pending_q.size() == 0) begin
					n_errors++;
					$display("%0t: unexpected result %p", $time, result);
				end else begin
					want = pending_q.pop_front();
					if (result !== want) begin
						n_errors++;
						$display("%0t: mismatch expected %p actual %p", $time, want, result);
					end
				end
			end
			if (burst > 0) begin
				burst--;
				result_stall <= 1'b1;
			end else if (!quiet_sink && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(0, 11);
				result_stall <= 1'b1;
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	// Offer one request, hold it until taken, then predict its results
	task automatic send_ball(input cci_pkg::ball_t b, input bit allow_gap);
		int gap;
		if (allow_gap && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 12);
			ball_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ball_valid <= 1'b1;
		ball <= b;
		do @(posedge clk); while (ball_stall);
		predict_collision(b);
	endtask

	task automatic wait_drain();
		int guard;
		guard = 0;
		while (pending_q.size() != 0 && guard < 100000) begin
			@(posedge clk);
			guard++;
		end
	endtask

	initial begin
		int status_seen;
		cci_pkg::ball_t a;
		cci_pkg::ball_t b;
		arst_n = 1'b0;
		ball_valid = 1'b0;
		ball = '0;
		a_loaded = 0;
		quiet_sink = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table; typed status checked on the queued expectation too
		for (int i = 0; i < N_DIRECTED; i++) begin
			send_ball(dir_ball[i], 1'b1);
			if (dir_status[i] >= 0 && pending_q.size() != 0) begin
				status_seen = pending_q[pending_q.size() - 1].status;
				if (status_seen != dir_status[i]) begin
					n_errors++;
					$display("%0t: row %0d status expected %0d actual %0d", $time, i,
						dir_status[i], status_seen);
				end
			end
		end

		// Hold off until every expected result has come
		ball_valid <= 1'b0;
		@(posedge clk);
		wait_drain();

		// Random part: mostly well-formed pairs, some stray B or lone A
		for (int i = 0; i < N_RANDOM; ) begin
			if (i > N_RANDOM - 60) quiet_sink = 1;
			a = random_ball(0);
			b = random_ball(1);
			if ($urandom_range(0, 19) == 0) b.pos_x = a.pos_x;
			if ($urandom_range(0, 19) == 0) b.pos_y = a.pos_y;
			if ($urandom_range(0, 9) != 0) begin
				send_ball(a, i <= N_RANDOM - 60);
				i++;
			end
			if ($urandom_range(0, 9) != 0) begin
				send_ball(b, i <= N_RANDOM - 60);
				i++;
			end
		end
		ball_valid <= 1'b0;
		wait_drain();
		repeat (200) @(posedge clk);

		$display("Sent %0d directed and about %0d random balls; %0d results checked.",
			N_DIRECTED, N_RANDOM, n_results);
		if (pending_q.size() != 0) begin
			n_errors++;
			$display("%0t: %0d expected results never arrived", $time, pending_q.size());
		end
		if (n_errors == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

[files.f]
rtl/core/cci_pkg.sv
rtl/core/circle_collision_impulse_resolver.sv
rtl/core/cci_checker.sv
tb/sv/circle_collision_impulse_resolver_test.sv
